### rtl/sliding_window_mean_stream_core_assert.svh
// Assertion macros for the sliding window mean stream core.
// Include guard only; no dependencies.
`ifndef SLIDING_WINDOW_MEAN_STREAM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_STREAM_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/swm_pkg.sv
// Shared constants and types for the sliding window mean stream core.
// No dependencies.
package swm_pkg;

   localparam int WINDOW_MAX    = 64;
   localparam int SAMPLE_BITS   = 32;
   localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
   localparam int LEN_BITS      = $clog2(WINDOW_MAX + 1);
   localparam int CNT_BITS      = LEN_BITS;
   localparam int SUM_BITS      = SAMPLE_BITS + SLOT_BITS;
   localparam int ITER_BITS     = $clog2(SUM_BITS + 1);
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int REG_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = '0;
   localparam logic [LEN_BITS-1:0]     LEN_RESET = LEN_BITS'(WINDOW_MAX);

   localparam logic REQ_PRESENT = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/swm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/swm_div.sv
// Serial restoring divider: signed sum over unsigned count, one quotient bit per cycle.
// Depends on swm_pkg.
module swm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [swm_pkg::SUM_BITS-1:0] dividend,
   input  logic [swm_pkg::CNT_BITS-1:0]       divisor,
   output swm_pkg::div_status_type            status,
   output logic [swm_pkg::SAMPLE_BITS-1:0]    quotient
);
   import swm_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   neg_ff, neg_in;
   logic [SUM_BITS-1:0]    work_ff, work_in;
   logic [CNT_BITS-1:0]    rem_ff, rem_in;
   logic [ITER_BITS-1:0]   iter_ff, iter_in;
   logic [SAMPLE_BITS-1:0] quot_ff, quot_in;
   logic [CNT_BITS:0]      rem_shift;
   logic [CNT_BITS:0]      rem_diff;
   logic                   fits;

   assign rem_shift = {rem_ff, work_ff[SUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};
   assign fits      = rem_shift >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      quot_in = quot_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_BITS-1];
         work_in = dividend[SUM_BITS-1] ? (SUM_BITS'(0) - SUM_BITS'(dividend))
                                        : SUM_BITS'(dividend);
         rem_in  = '0;
         iter_in = ITER_BITS'(SUM_BITS);
      end else if (busy_ff) begin
         if (iter_ff != '0) begin
            work_in = {work_ff[SUM_BITS-2:0], fits};
            rem_in  = fits ? rem_diff[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
            iter_in = iter_ff - ITER_BITS'(1);
         end else begin
            quot_in = neg_ff ? (SAMPLE_BITS'(0) - work_ff[SAMPLE_BITS-1:0])
                             : work_ff[SAMPLE_BITS-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      neg_ff  <= neg_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;
endmodule

### rtl/sliding_window_mean_stream_core.sv
// Sliding window mean stream core: top level, sequencer, ring state and register port.
// Depends on swm_pkg, swm_ram, swm_div and sliding_window_mean_stream_core_assert.svh.
//
// Usage:
//  - req channel (req_valid/req_ready): one transaction per sample, req_type 0 = present
//    sample (req_sample, signed Q16.16), 1 = missing sample marker.
//  - rsp channel (rsp_valid/rsp_ready): one transaction per request with the truncated
//    mean, mean_valid (0 when no present sample is in the window, mean then 0) and the
//    present count.
//  - csr port: window_length at byte address 0 (1..64 in bits 6:0, out of range values
//    saturate); writing it clears ring, sum, count. Write only while the core is idle.
// Sequencing: req_ready is high only in the idle state, so the core takes no new request
// while one is in process. With a present sample in the window a request passes the
// remove, insert and start states (the last loads the divider), 38 divider steps, the
// quotient cycle, the done cycle and the output load, and then rsp_valid rises. An empty
// window skips the divider and goes from the start state to the output load. req_ready
// rises together with rsp_valid. A stalled receiver holds one result in the output
// register while the next request is processed; that request then waits for the
// register and req_ready stays low. Reset: window_length returns to 64.
module sliding_window_mean_stream_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic signed [swm_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [swm_pkg::SAMPLE_BITS-1:0] rsp_mean,
   output logic                               rsp_mean_valid,
   output logic [swm_pkg::CNT_BITS-1:0]       rsp_present_count,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [swm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [swm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import swm_pkg::*;

`include "sliding_window_mean_stream_core_assert.svh"

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REMOVE = 6'b000010,
      S_INSERT = 6'b000100,
      S_START  = 6'b001000,
      S_DIV    = 6'b010000,
      S_OUT    = 6'b100000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [LEN_BITS-1:0]    window_len_ff, window_len_in;
   logic [WINDOW_MAX-1:0]  present_ff, present_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [LEN_BITS-1:0]    filled_ff, filled_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   type_ff, type_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic                   rsp_mean_valid_ff, rsp_mean_valid_in;
   logic [CNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic                   req_fire;
   logic                   cfg_write;
   logic [LEN_BITS-1:0]    cfg_len_raw;
   logic [LEN_BITS-1:0]    cfg_len;
   logic                   full;
   logic [LEN_BITS-1:0]    slot_next;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic                   ram_wr_en;
   logic                   div_start;
   div_status_type         div_stat;
   logic [SAMPLE_BITS-1:0] div_quot;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW_LENGTH);
   assign cfg_len_raw = csr_pwdata[LEN_BITS-1:0];
   assign cfg_len = (cfg_len_raw == '0) ? LEN_BITS'(1)
                  : (cfg_len_raw > LEN_RESET) ? LEN_RESET : cfg_len_raw;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_WINDOW_LENGTH)
                       ? CSR_DATA_BITS'(window_len_ff) : '0;

   assign full      = (filled_ff >= window_len_ff);
   assign slot_next = LEN_BITS'(slot_ff) + LEN_BITS'(1);
   assign ram_wr_en = (state_ff == S_INSERT) && (type_ff == REQ_PRESENT);
   assign div_start = (state_ff == S_START) && (count_ff != '0);

   swm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_fire),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   swm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .status   (div_stat),
      .quotient (div_quot)
   );

   always_comb begin
      state_in          = state_ff;
      window_len_in     = window_len_ff;
      present_in        = present_ff;
      slot_in           = slot_ff;
      filled_in         = filled_ff;
      sum_in            = sum_ff;
      count_in          = count_ff;
      type_in           = type_ff;
      sample_in         = sample_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_mean_in       = rsp_mean_ff;
      rsp_mean_valid_in = rsp_mean_valid_ff;
      rsp_count_in      = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               type_in   = req_type;
               sample_in = req_sample;
               state_in  = S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (full && present_ff[slot_ff]) begin
               sum_in = sum_ff - {{(SUM_BITS-SAMPLE_BITS){ram_rd_data[SAMPLE_BITS-1]}},
                                  ram_rd_data};
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
            state_in = S_INSERT;
         end
         S_INSERT: begin
            present_in[slot_ff] = (type_ff == REQ_PRESENT);
            if (type_ff == REQ_PRESENT) begin
               sum_in   = sum_ff + {{(SUM_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}},
                                    sample_ff};
               count_in = count_ff + CNT_BITS'(1);
            end
            slot_in = (slot_next >= window_len_ff) ? '0 : slot_next[SLOT_BITS-1:0];
            if (!full) begin
               filled_in = filled_ff + LEN_BITS'(1);
            end
            state_in = S_START;
         end
         S_START: begin
            state_in = (count_ff != '0) ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_mean_valid_in = (count_ff != '0);
               rsp_mean_in       = (count_ff != '0) ? div_quot : '0;
               rsp_count_in      = count_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_write) begin
         window_len_in = cfg_len;
         present_in    = '0;
         slot_in       = '0;
         filled_in     = '0;
         sum_in        = '0;
         count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         window_len_ff <= LEN_RESET;
         present_ff    <= '0;
         slot_ff       <= '0;
         filled_ff     <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         present_ff    <= present_in;
         slot_ff       <= slot_in;
         filled_ff     <= filled_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      type_ff           <= type_in;
      sample_ff         <= sample_in;
      rsp_mean_ff       <= rsp_mean_in;
      rsp_mean_valid_ff <= rsp_mean_valid_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean          = rsp_mean_ff;
   assign rsp_mean_valid    = rsp_mean_valid_ff;
   assign rsp_present_count = rsp_count_ff;

   `SWM_ASSERT_NOW(a_count_in_window, 1'b1, count_ff <= filled_ff,
      "present count exceeds filled slots")
   `SWM_ASSERT_NOW(a_filled_in_window, 1'b1, filled_ff <= window_len_ff,
      "filled slots exceed window length")
   `SWM_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_ff == S_DIV,
      "divider finished outside its wait state")
   `SWM_ASSERT_NOW(a_div_alive, state_ff == S_DIV, div_stat.busy || div_stat.done,
      "sequencer waits on an idle divider")
   `SWM_ASSERT_NEXT(a_result_flag, (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready),
      rsp_valid_ff && (rsp_mean_valid_ff == (rsp_count_ff != '0)),
      "mean valid flag disagrees with present count")
endmodule

### tb/tb_sliding_window_mean_stream_core.sv
// Self-checking testbench for sliding_window_mean_stream_core: windowed mean tracker,
// directed and randomized sample streams, random idling and a long receiver hold-off.
// Depends on swm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_sliding_window_mean_stream_core;
   import swm_pkg::*;

   localparam logic REQ_MISSING = ~REQ_PRESENT;
   localparam logic [CSR_ADDR_BITS-1:0] LENGTH_ADDR   = {REG_WINDOW_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = {~REG_WINDOW_LENGTH, 2'b00};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      logic [SAMPLE_BITS-1:0] mean;
      logic                   mean_valid;
      logic [CNT_BITS-1:0]    count;
   } window_mean_type;

   class mean_tracker;
      longint          ring_value[WINDOW_MAX];
      bit              ring_present[WINDOW_MAX];
      int              write_slot;
      int              slots_filled;
      longint          running_total;
      int              present_count;
      int              window_len;
      int              mismatches;
      window_mean_type pending_means[$];

      function new();
         window_len = WINDOW_MAX;
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         for (int i = 0; i < WINDOW_MAX; i++) begin
            ring_value[i] = 0;
            ring_present[i] = 0;
         end
         write_slot = 0;
         slots_filled = 0;
         running_total = 0;
         present_count = 0;
      endfunction

      function void set_length(logic [31:0] value);
         int wl;
         wl = value[6:0];
         if (wl < 1) wl = 1;
         if (wl > WINDOW_MAX) wl = WINDOW_MAX;
         window_len = wl;
         clear();
      endfunction

      task report(string what, longint got, longint want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      function void note_sample(logic kind, logic [SAMPLE_BITS-1:0] raw);
         bit              present;
         bit              full;
         int              slot;
         window_mean_type res;
         present = (kind == REQ_PRESENT);
         full = slots_filled >= window_len;
         slot = write_slot;
         if (full && ring_present[slot]) begin
            running_total -= ring_value[slot];
            if (present_count > 0) present_count--;
         end
         ring_present[slot] = present;
         ring_value[slot] = present ? longint'($signed(raw)) : 0;
         if (present) begin
            running_total += longint'($signed(raw));
            present_count++;
         end
         slot++;
         write_slot = (slot >= window_len) ? 0 : slot;
         if (!full) slots_filled++;
         if (present_count == 0) begin
            res.mean = '0;
            res.mean_valid = 1'b0;
            res.count = '0;
         end else begin
            res.mean = SAMPLE_BITS'(running_total / longint'(present_count));
            res.mean_valid = 1'b1;
            res.count = CNT_BITS'(present_count);
         end
         pending_means.push_back(res);
      endfunction

      task check_result(logic [SAMPLE_BITS-1:0] mean, logic mean_valid,
                        logic [CNT_BITS-1:0] count);
         window_mean_type want;
         if (pending_means.size() == 0) begin
            report("result with no pending transaction", longint'($signed(mean)), 0);
         end else begin
            want = pending_means.pop_front();
            if (mean !== want.mean)
               report("mean", longint'($signed(mean)), longint'($signed(want.mean)));
            if (mean_valid !== want.mean_valid)
               report("mean_valid", mean_valid, want.mean_valid);
            if (count !== want.count)
               report("present_count", count, want.count);
         end
      endtask

      task check_length(logic [31:0] rdata);
         if (rdata !== 32'(window_len))
            report("window_length readback", rdata, window_len);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_PRESENT;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_mean;
   logic rsp_mean_valid;
   logic [CNT_BITS-1:0] rsp_present_count;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   mean_tracker tracker;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  phase_length[8] = '{127, 1, 133, 2, 0, 64, 17, 7};

   sliding_window_mean_stream_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mean(rsp_mean),
      .rsp_mean_valid(rsp_mean_valid),
      .rsp_present_count(rsp_present_count),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_sample(req_type, req_sample);
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_mean, rsp_mean_valid, rsp_present_count);
      end
   end

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // all driver tasks start and end just after a falling edge
   task automatic send_sample(input logic kind, input logic [SAMPLE_BITS-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_means.size() > 0) @(negedge clock);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] wdata,
                            output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] unused;
      csr_cycle(1'b1, addr, value, unused);
      if (addr == LENGTH_ADDR) tracker.set_length(value);
   endtask

   task automatic read_length();
      logic [CSR_DATA_BITS-1:0] rdata;
      csr_cycle(1'b0, LENGTH_ADDR, '0, rdata);
      tracker.check_length(rdata);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 5))
         0: v = SAMPLE_MAX;
         1: v = SAMPLE_MIN;
         2: v = SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // runs: mixed, constant extreme, missing burst, alternating extremes, sparse
   task automatic run_random(input int n);
      int left;
      int mode;
      int len;
      int wl;
      logic kind;
      logic [SAMPLE_BITS-1:0] fixed_val;
      logic [SAMPLE_BITS-1:0] value;
      left = n;
      while (left > 0) begin
         wl = tracker.window_len;
         mode = $urandom_range(0, 9);
         if (mode == 6 || mode == 7) len = wl + $urandom_range(0, 3);
         else len = $urandom_range(1, 2 * wl + 4);
         if (len > left) len = left;
         fixed_val = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         for (int i = 0; i < len; i++) begin
            value = pick_sample();
            kind = REQ_PRESENT;
            case (mode)
               6: value = fixed_val;
               7: kind = REQ_MISSING;
               8: value = i[0] ? SAMPLE_MAX : SAMPLE_MIN;
               9: kind = ($urandom_range(0, 7) == 0) ? REQ_PRESENT : REQ_MISSING;
               default: kind = ($urandom_range(0, 3) == 0) ? REQ_MISSING : REQ_PRESENT;
            endcase
            send_sample(kind, value);
         end
         left -= len;
      end
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      read_length();

      // empty window, extremes, truncation toward zero
      send_sample(REQ_MISSING, 32'h1234_5678);
      send_sample(REQ_PRESENT, SAMPLE_MAX);
      send_sample(REQ_PRESENT, SAMPLE_MIN);
      send_sample(REQ_PRESENT, 32'h0000_0000);
      send_sample(REQ_PRESENT, 32'hFFFF_FFFF);
      send_sample(REQ_PRESENT, 32'h0000_0001);
      send_sample(REQ_MISSING, 32'hFFFF_FFFF);
      drain();

      // zero length saturates to one slot
      write_csr(LENGTH_ADDR, 32'd0);
      read_length();
      send_sample(REQ_PRESENT, 32'hFFFF_FFFB);
      send_sample(REQ_MISSING, 32'h0000_0000);
      send_sample(REQ_PRESENT, 32'h0000_0007);
      drain();

      write_csr(LENGTH_ADDR, 32'd2);
      read_length();
      send_sample(REQ_PRESENT, 32'hFFFF_FFFD);
      send_sample(REQ_PRESENT, 32'h0000_0002);
      send_sample(REQ_PRESENT, SAMPLE_MIN);
      drain();

      // unmapped register: ignored, window state kept
      write_csr(UNMAPPED_ADDR, 32'd9);
      read_length();
      send_sample(REQ_PRESENT, SAMPLE_MAX);
      send_sample(REQ_MISSING, 32'hA5A5_A5A5);
      drain();

      // oversize length saturates to the maximum
      write_csr(LENGTH_ADDR, 32'd100);
      read_length();

      for (int p = 0; p < 8; p++) begin
         drain();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         write_csr(LENGTH_ADDR, phase_length[p]);
         read_length();
         if (p == 2) hold_request = 1;
         run_random(52 + 2 * tracker.window_len);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_means.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_div.sv
rtl/sliding_window_mean_stream_core.sv
tb/tb_sliding_window_mean_stream_core.sv
